// File: rtl/satb_pkg.sv
package satb_pkg;

  // input word: one command to the bank
  typedef struct packed {
    logic        action;
    logic [7:0]  sleeper_id;
    logic [31:0] duration;
  } in_word_t;

  // result word: acceptance, refusal or wake
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  woken_id;
    logic [62:0] tick_now;
    logic        last;
  } out_word_t;

  // one alarm slot as held in the bank memory
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] remaining;
  } slot_t;

  // action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_SLEEP = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REFUSE = 2'd1;
  localparam logic [1:0] KIND_WAKE   = 2'd2;

  // wakes reported per tick at most
  localparam int WAKE_CNT_W = 5;
  localparam logic [WAKE_CNT_W-1:0] MAX_WAKES = 5'd16;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } satb_state_t;

  // controller to datapath
  typedef struct packed {
    logic sleep_go;
    logic tick_go;
    logic walk_en;
    logic flush;
  } satb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bank_empty;
    logic scan_done;
  } satb_status_t;

endpackage

// File: rtl/satb_ctrl.sv
module satb_ctrl
  import satb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         action,
  input  satb_status_t status,
  output logic         busy,
  output satb_cmd_t    cmd
);

  satb_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (action == ACT_SLEEP) begin
            cmd.sleep_go = 1'b1;
          end else begin
            cmd.tick_go = 1'b1;
            if (!status.bank_empty) begin
              state_nxt = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        cmd.walk_en = 1'b1;
        if (status.scan_done) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/satb_dp.sv
module satb_dp
  import satb_pkg::*;
#(
  parameter int ALARM_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  in_word_t     in_word,
  input  satb_cmd_t    cmd,
  output satb_status_t status,
  output logic         out_valid,
  output out_word_t    out_word
);

  localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
  localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(ALARM_SLOTS);

  // bank memory, one write and one registered read a cycle
  slot_t mem_r [ALARM_SLOTS];
  slot_t rd_data_r;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic                  rdv_r, rdv_nxt;
  logic [WAKE_CNT_W-1:0] wake_n_r, wake_n_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [7:0]            pend_id_r, pend_id_nxt;
  logic [62:0]           tick_r, tick_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;

  logic             full;
  logic             scan_left;
  logic             scan_issue;
  logic             expire;
  logic             keep;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;

  assign full       = (count_r == SLOTS_C);
  assign scan_left  = (rd_ptr_r < count_r);
  assign scan_issue = cmd.walk_en && scan_left;
  assign expire     = rdv_r && (rd_data_r.remaining <= 32'd1) && (wake_n_r < MAX_WAKES);
  assign keep       = rdv_r && !expire;

  assign status.bank_empty = (count_r == '0);
  assign status.scan_done  = !scan_left && !rdv_r;

  // memory write: append on sleep, compact survivors on walk
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_r[IDX_W-1:0];
    mem_wdata = rd_data_r;
    if (cmd.sleep_go) begin
      mem_we    = !full;
      mem_waddr = count_r[IDX_W-1:0];
      mem_wdata = '{id: in_word.sleeper_id, remaining: in_word.duration};
    end else if (keep) begin
      mem_we               = 1'b1;
      mem_wdata.remaining  = (rd_data_r.remaining == 32'd0) ? 32'd0
                                                             : rd_data_r.remaining - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (scan_issue) begin
      rd_data_r <= mem_r[rd_ptr_r[IDX_W-1:0]];
    end
  end

  // walk, wake holding and result register
  always_comb begin
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    rdv_nxt       = scan_issue;
    wake_n_nxt    = wake_n_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    tick_nxt      = tick_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    if (cmd.sleep_go) begin
      out_valid_nxt         = 1'b1;
      out_word_nxt.kind     = full ? KIND_REFUSE : KIND_ACCEPT;
      out_word_nxt.woken_id = in_word.sleeper_id;
      out_word_nxt.tick_now = tick_r;
      out_word_nxt.last     = 1'b1;
      if (!full) begin
        count_nxt = count_r + 1'b1;
      end
    end

    if (cmd.tick_go) begin
      tick_nxt   = tick_r + 63'd1;
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      wake_n_nxt = '0;
      pend_v_nxt = 1'b0;
    end

    if (scan_issue) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end

    // an expiring slot sends out the wake held before it
    if (expire) begin
      if (pend_v_r) begin
        out_valid_nxt         = 1'b1;
        out_word_nxt.kind     = KIND_WAKE;
        out_word_nxt.woken_id = pend_id_r;
        out_word_nxt.tick_now = tick_r;
        out_word_nxt.last     = 1'b0;
      end
      pend_v_nxt  = 1'b1;
      pend_id_nxt = rd_data_r.id;
      wake_n_nxt  = wake_n_r + 1'b1;
    end else if (keep) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end

    // end of walk: final wake marked last, bank keeps only the survivors
    if (cmd.flush) begin
      if (pend_v_r) begin
        out_valid_nxt         = 1'b1;
        out_word_nxt.kind     = KIND_WAKE;
        out_word_nxt.woken_id = pend_id_r;
        out_word_nxt.tick_now = tick_r;
        out_word_nxt.last     = 1'b1;
      end
      pend_v_nxt = 1'b0;
      count_nxt  = wr_ptr_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      rdv_r       <= 1'b0;
      wake_n_r    <= '0;
      pend_v_r    <= 1'b0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rdv_r       <= rdv_nxt;
      wake_n_r    <= wake_n_nxt;
      pend_v_r    <= pend_v_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/sleep_alarm_timer_bank_top.sv
// sleep request: one result in the cycle after acceptance; busy stays low, a new word each cycle
// tick with N > 0 pending alarms: busy through the memory walk, which reads one slot a cycle
// tick on an empty bank: no result and busy stays low
// wakes leave in arrival order during the walk, the last one in the same cycle that busy falls
// results are single-cycle strobes; the receiver cannot stall
// synchronous active-low reset clears tick count and alarm count; memory is not cleared
module sleep_alarm_timer_bank_top
  import satb_pkg::*;
#(
  parameter int ALARM_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      out_valid,
  output out_word_t out_word
);

  satb_cmd_t    cmd;
  satb_status_t status;

  // sequencer
  satb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_word.action),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // bank, tick count and result register
  satb_dp #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// File: rtl/satb_checker.sv
module satb_props
  import satb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input in_word_t  in_word,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  // a sleep request answers on the next cycle, marked last
  a_sleep_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.action == ACT_SLEEP) |=> out_valid && out_word.last)
    else $error("sleep request not answered on next cycle");

  // a sleep request leaves the block free
  a_sleep_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.action == ACT_SLEEP) |=> !busy)
    else $error("busy raised by sleep request");

  // acceptance and refusal are always single results
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind != KIND_WAKE) |-> out_word.last)
    else $error("non-wake result without last");

  // a wake that is not last belongs to a walk still in progress
  a_wake_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind == KIND_WAKE) && !out_word.last |-> busy)
    else $error("intermediate wake outside a walk");

  // no undefined kind code
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.kind == KIND_ACCEPT) || (out_word.kind == KIND_REFUSE) ||
                  (out_word.kind == KIND_WAKE))
    else $error("undefined result kind");

endmodule

bind sleep_alarm_timer_bank_top satb_props u_satb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_word   (in_word),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

// File: bench/satb_checker.sv
`timescale 1ns / 1ps

// watches both channels, predicts the bank and compares every result word
module satb_checker
  import satb_pkg::*;
#(
  parameter int ALARM_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  out_word_t out_word,
  input  logic      drain_done,
  output int        fail_count,
  output int        exp_left
);

  // own copy of the bank
  logic [62:0]  ticks;
  logic [7:0]   slot_id   [ALARM_SLOTS];
  logic [31:0]  slot_left [ALARM_SLOTS];
  int unsigned  slot_used;

  out_word_t due_words[$];
  int        errs = 0;
  logic      drain_seen = 1'b0;

  assign fail_count = errs;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
    errs++;
  endtask

  // apply one accepted command word and queue the words it should cause
  task automatic bank_apply(input in_word_t w);
    out_word_t   r;
    out_word_t   wk [16];
    int unsigned wr;
    int          n;
    r = '0;
    if (w.action == ACT_SLEEP) begin
      r.woken_id = w.sleeper_id;
      r.tick_now = ticks;
      r.last     = 1'b1;
      if (slot_used < ALARM_SLOTS) begin
        slot_id[slot_used]   = w.sleeper_id;
        slot_left[slot_used] = w.duration;
        slot_used++;
        r.kind = KIND_ACCEPT;
      end else begin
        r.kind = KIND_REFUSE;
      end
      due_words.push_back(r);
    end else begin
      ticks = ticks + 63'd1;
      wr = 0;
      n  = 0;
      // walk in arrival order, compacting the survivors
      for (int rd = 0; rd < slot_used; rd++) begin
        if (slot_left[rd] <= 32'd1 && n < int'(MAX_WAKES)) begin
          wk[n].kind     = KIND_WAKE;
          wk[n].woken_id = slot_id[rd];
          wk[n].tick_now = ticks;
          wk[n].last     = 1'b0;
          n++;
        end else begin
          slot_id[wr]   = slot_id[rd];
          slot_left[wr] = (slot_left[rd] > 32'd0) ? slot_left[rd] - 32'd1 : 32'd0;
          wr++;
        end
      end
      slot_used = wr;
      if (n > 0) wk[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) due_words.push_back(wk[k]);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      ticks     = '0;
      slot_used = 0;
      due_words.delete();
      exp_left <= 0;
    end else begin
      // results first: they belong to earlier words
      if (out_valid) begin
        if (due_words.size() == 0) begin
          report_mismatch("result word with nothing due", 64'(out_word), 64'd0);
        end else begin
          want = due_words.pop_front();
          if (out_word.kind !== want.kind)
            report_mismatch("kind", 64'(out_word.kind), 64'(want.kind));
          if (out_word.woken_id !== want.woken_id)
            report_mismatch("woken_id", 64'(out_word.woken_id), 64'(want.woken_id));
          if (out_word.tick_now !== want.tick_now)
            report_mismatch("tick_now", 64'(out_word.tick_now), 64'(want.tick_now));
          if (out_word.last !== want.last)
            report_mismatch("last", 64'(out_word.last), 64'(want.last));
        end
      end
      if (start && !busy) bank_apply(in_word);
      // end of run: anything still due never came
      if (drain_done && !drain_seen) begin
        drain_seen = 1'b1;
        if (due_words.size() != 0)
          report_mismatch("result words never arrived", 64'(due_words.size()), 64'd0);
      end
      exp_left <= due_words.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import satb_pkg::*;

  localparam int ALARM_SLOTS = 16;
  localparam int END_WAIT    = ALARM_SLOTS + 8;
  localparam int RAND_WORDS  = 205;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      start      = 1'b0;
  in_word_t  in_word    = '0;
  logic      drain_done = 1'b0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;
  int        fail_count;
  int        exp_left;
  int        burst_left = 0;

  always #1 clk = ~clk;

  sleep_alarm_timer_bank_top #(.ALARM_SLOTS(ALARM_SLOTS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  satb_checker #(.ALARM_SLOTS(ALARM_SLOTS)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .drain_done (drain_done),
    .fail_count (fail_count),
    .exp_left   (exp_left)
  );

  // present one command word and hold it until the bank takes it
  task automatic send_cmd(input logic act, input logic [7:0] id, input logic [31:0] dur);
    in_word_t w;
    w.action     = act;
    w.sleeper_id = id;
    w.duration   = dur;
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start with noise on the word; n sets the length of the gap
  task automatic idle_for(input int n);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    start   <= 1'b0;
    in_word <= noise[$bits(in_word_t)-1:0];
    repeat (n) @(posedge clk);
  endtask

  // bursts of back-to-back words with random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(20, 40);
      else burst_left = $urandom_range(1, 10);
      idle_for($urandom_range(1, 6));
    end
  endtask

  // hold off until every due result word has come, bounded
  task automatic wait_drained();
    int guard;
    guard = 0;
    idle_for(2);
    while (exp_left != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    #200000;
    $display("sleep_alarm_timer_bank_top test failed");
    $finish;
  end

  initial begin
    logic [7:0]  id;
    logic [31:0] dur;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // tick on an empty bank, ignored fields all ones
    send_cmd(ACT_TICK, 8'hFF, 32'hFFFF_FFFF);
    pace();
    // fill every slot with alarms due on the next tick
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      id = (i == ALARM_SLOTS - 1) ? 8'hFF : 8'(i * 17);
      send_cmd(ACT_SLEEP, id, 32'(i % 2));
      pace();
    end
    // bank full: refused
    send_cmd(ACT_SLEEP, 8'h5A, 32'd3);
    pace();
    // sixteen wakes in one tick
    send_cmd(ACT_TICK, 8'h00, 32'd0);
    pace();
    // longest duration stays pending for good
    send_cmd(ACT_SLEEP, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(ACT_SLEEP, 8'h3C, 32'd2);
    send_cmd(ACT_SLEEP, 8'h00, 32'd0);
    pace();
    repeat (3) begin
      send_cmd(ACT_TICK, 8'(($urandom)), $urandom);
      pace();
    end

    // random traffic, mostly short sleeps so wakes keep coming
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == RAND_WORDS / 2) wait_drained();
      if ($urandom_range(0, 99) < 45) begin
        send_cmd(ACT_TICK, 8'($urandom), $urandom);
      end else begin
        dur = ($urandom_range(0, 39) == 0) ? $urandom : 32'($urandom_range(0, 6));
        send_cmd(ACT_SLEEP, 8'($urandom), dur);
      end
      pace();
    end

    // drain and give the verdict
    wait_drained();
    repeat (END_WAIT) @(posedge clk);
    drain_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("sleep_alarm_timer_bank_top test passed");
    end else begin
      $display("sleep_alarm_timer_bank_top test failed");
    end
    $finish;
  end

endmodule
